@@ hdl/mass_storage_descriptor_scan_assert.svh @@
// Assertion macros used by the checker file of the descriptor scanner.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef MASS_STORAGE_DESCRIPTOR_SCAN_ASSERT_SVH
`define MASS_STORAGE_DESCRIPTOR_SCAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("descriptor scanner check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("descriptor scanner check failed");

`endif

@@ hdl/msds_pkg.sv @@
`default_nettype none

package msds_pkg;

    // One byte of the descriptor set.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // Summary produced on the final byte of a set.
    typedef struct packed {
        logic        found;
        logic [7:0]  config_value;
        logic [3:0]  in_endpoint;
        logic [15:0] in_max_packet;
        logic [3:0]  out_endpoint;
        logic [15:0] out_max_packet;
    } out_item_t;

    // Descriptor type codes.
    localparam logic [7:0] TYPE_CONFIG    = 8'h02;
    localparam logic [7:0] TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;

    // Interface class triple for SCSI bulk-only mass storage.
    localparam logic [7:0] CLASS_MSC     = 8'h08;
    localparam logic [7:0] SUBCLASS_SCSI = 8'h06;
    localparam logic [7:0] PROTO_BOT     = 8'h50;

    // Endpoint attribute and address fields.
    localparam logic [7:0] XFER_MASK   = 8'h03;
    localparam logic [7:0] XFER_BULK   = 8'h02;
    localparam logic [7:0] DIR_IN_BIT  = 8'h80;
    localparam logic [7:0] EP_NUM_MASK = 8'h0F;

    // Header geometry and minimum descriptor lengths.
    localparam logic [3:0] HEADER_BYTES   = 4'd9;
    localparam int         DESC_FIELDS    = 6;
    localparam logic [7:0] IF_MIN_SIZE    = 8'd8;
    localparam logic [7:0] EP_MIN_SIZE    = 8'd6;
    localparam logic [7:0] DESC_MIN_SIZE  = 8'd2;
    localparam logic [7:0] FIELDS_END_POS = 8'd8;

endpackage

`default_nettype wire

@@ hdl/mass_storage_descriptor_scan.sv @@
// Channel   Direction  Handshake                  Payload
// byte      in         byte_valid / byte_stall    byte_item   (data_byte, last_byte)
// result    out        result_valid / result_stall result_item (found .. out_max_packet)
//
// One byte is taken every cycle unless the input register is stalled; each byte
// is held in the input register and is folded into the scan state as it leaves.
// A result enters the result register as its final byte leaves the input register.
// Reset clears all scan state and both valid flags; a final byte clears the scan state.
// Only a final byte waits on a stalled result; while it waits, no new byte is taken.
`default_nettype none

module mass_storage_descriptor_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire msds_pkg::in_item_t  byte_item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output msds_pkg::out_item_t      result_item
);
    import msds_pkg::*;

    in_item_t  stage_item;
    out_item_t res_item;
    logic      fire;
    logic      hold_last;

    // A final byte may only proceed once the result register can take its summary.
    assign hold_last = result_valid && result_stall;

    msds_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .hold_last  (hold_last),
        .fire       (fire),
        .stage_item (stage_item)
    );

    msds_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .stage_item (stage_item),
        .res_item   (res_item)
    );

    msds_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && stage_item.last_byte),
        .res_item     (res_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

@@ hdl/msds_in_reg.sv @@
`default_nettype none

module msds_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire msds_pkg::in_item_t byte_item,
    input  wire logic              hold_last,
    output logic                   fire,
    output msds_pkg::in_item_t     stage_item
);
    import msds_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;
    logic     load;

    // A held item moves on unless it is a final byte and the result is still waiting.
    assign fire       = vld_reg && !(item_reg.last_byte && hold_last);
    assign byte_stall = vld_reg && !fire;
    assign load       = byte_valid && !byte_stall;
    assign stage_item = item_reg;

    // Valid flag of the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            vld_reg <= 1'b0;
        end
    end

    // Payload of the input stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= byte_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/msds_walk.sv @@
`default_nettype none

module msds_walk (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire msds_pkg::in_item_t stage_item,
    output msds_pkg::out_item_t     res_item
);
    import msds_pkg::*;

    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] hlen_reg, hlen_next;
    logic       hdr_ok_reg, hdr_ok_next;
    logic [7:0] cfg_reg, cfg_next;
    logic       started_reg, started_next;
    logic       stopped_reg, stopped_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] fields_reg [DESC_FIELDS];
    logic [7:0] fields_next [DESC_FIELDS];
    logic       match_reg, match_next;
    logic       have_in_reg, have_in_next;
    logic       have_out_reg, have_out_next;
    logic [3:0] in_num_reg, in_num_next;
    logic [15:0] in_mps_reg, in_mps_next;
    logic [3:0] out_num_reg, out_num_next;
    logic [15:0] out_mps_reg, out_mps_next;

    logic [7:0] b;
    logic [7:0] walk_pos;
    logic [2:0] fld_idx;
    logic       found;

    assign b       = stage_item.data_byte;
    assign fld_idx = 3'(walk_pos - DESC_MIN_SIZE);

    // Next state for one byte: header capture, walk start, descriptor walk.
    always_comb
    begin
        cnt_next      = cnt_reg;
        hlen_next     = hlen_reg;
        hdr_ok_next   = hdr_ok_reg;
        cfg_next      = cfg_reg;
        started_next  = started_reg;
        stopped_next  = stopped_reg;
        size_next     = size_reg;
        type_next     = type_reg;
        fields_next   = fields_reg;
        match_next    = match_reg;
        have_in_next  = have_in_reg;
        have_out_next = have_out_reg;
        in_num_next   = in_num_reg;
        in_mps_next   = in_mps_reg;
        out_num_next  = out_num_reg;
        out_mps_next  = out_mps_reg;
        walk_pos      = pos_reg;

        // Header fields by byte offset.
        if (cnt_reg == 4'd0)
        begin
            hlen_next = b;
        end
        else if (cnt_reg == 4'd1)
        begin
            hdr_ok_next = (b == TYPE_CONFIG);
        end
        else if (cnt_reg == 4'd5)
        begin
            cfg_next = b;
        end
        if (cnt_reg < HEADER_BYTES)
        begin
            cnt_next = cnt_reg + 4'd1;
        end

        // Before the walk, the position counts offsets up to the header length.
        if (!started_reg)
        begin
            if (pos_reg == hlen_next)
            begin
                started_next = 1'b1;
                walk_pos     = 8'd0;
            end
            else
            begin
                walk_pos = pos_reg + 8'd1;
            end
        end
        pos_next = walk_pos;

        // Descriptor walk.
        if (started_next && !stopped_reg)
        begin
            if (walk_pos == 8'd0)
            begin
                size_next = b;
                if (b < DESC_MIN_SIZE)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    pos_next = 8'd1;
                end
            end
            else
            begin
                if (walk_pos == 8'd1)
                begin
                    type_next = b;
                end
                else if (walk_pos < FIELDS_END_POS)
                begin
                    fields_next[fld_idx] = b;
                end

                if ({1'b0, walk_pos} + 9'd1 == {1'b0, size_reg})
                begin
                    pos_next = 8'd0;
                    // Act on the descriptor now that its last byte is in.
                    if (type_next == TYPE_INTERFACE)
                    begin
                        match_next = (size_reg >= IF_MIN_SIZE) &&
                                     (fields_next[3] == CLASS_MSC) &&
                                     (fields_next[4] == SUBCLASS_SCSI) &&
                                     (fields_next[5] == PROTO_BOT);
                        if (match_next && (have_in_reg || have_out_reg))
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                    else if (type_next == TYPE_ENDPOINT && match_reg &&
                             size_reg >= EP_MIN_SIZE)
                    begin
                        if ((fields_next[1] & XFER_MASK) == XFER_BULK)
                        begin
                            if ((fields_next[0] & DIR_IN_BIT) != 8'd0)
                            begin
                                if (!have_in_reg)
                                begin
                                    in_num_next  = 4'(fields_next[0] & EP_NUM_MASK);
                                    in_mps_next  = {fields_next[3], fields_next[2]};
                                    have_in_next = 1'b1;
                                end
                            end
                            else if (!have_out_reg)
                            begin
                                out_num_next  = 4'(fields_next[0] & EP_NUM_MASK);
                                out_mps_next  = {fields_next[3], fields_next[2]};
                                have_out_next = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    pos_next = walk_pos + 8'd1;
                end
            end
        end
    end

    // Summary of the set as it stands after this byte.
    always_comb
    begin
        found = (cnt_next >= HEADER_BYTES) && hdr_ok_next && have_in_next && have_out_next;
        res_item.found          = found;
        res_item.config_value   = found ? cfg_next : 8'd0;
        res_item.in_endpoint    = found ? in_num_next : 4'd0;
        res_item.in_max_packet  = found ? in_mps_next : 16'd0;
        res_item.out_endpoint   = found ? out_num_next : 4'd0;
        res_item.out_max_packet = found ? out_mps_next : 16'd0;
    end

    // Scanner state; a final byte returns everything to the reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= 4'd0;
            hlen_reg     <= 8'd0;
            hdr_ok_reg   <= 1'b0;
            cfg_reg      <= 8'd0;
            started_reg  <= 1'b0;
            stopped_reg  <= 1'b0;
            pos_reg      <= 8'd0;
            size_reg     <= 8'd0;
            type_reg     <= 8'd0;
            for (int i = 0; i < DESC_FIELDS; i++)
            begin
                fields_reg[i] <= 8'd0;
            end
            match_reg    <= 1'b0;
            have_in_reg  <= 1'b0;
            have_out_reg <= 1'b0;
            in_num_reg   <= 4'd0;
            in_mps_reg   <= 16'd0;
            out_num_reg  <= 4'd0;
            out_mps_reg  <= 16'd0;
        end
        else if (fire && stage_item.last_byte)
        begin
            // The set is complete, so the next byte starts a fresh one.
            cnt_reg      <= 4'd0;
            hlen_reg     <= 8'd0;
            hdr_ok_reg   <= 1'b0;
            cfg_reg      <= 8'd0;
            started_reg  <= 1'b0;
            stopped_reg  <= 1'b0;
            pos_reg      <= 8'd0;
            size_reg     <= 8'd0;
            type_reg     <= 8'd0;
            for (int i = 0; i < DESC_FIELDS; i++)
            begin
                fields_reg[i] <= 8'd0;
            end
            match_reg    <= 1'b0;
            have_in_reg  <= 1'b0;
            have_out_reg <= 1'b0;
            in_num_reg   <= 4'd0;
            in_mps_reg   <= 16'd0;
            out_num_reg  <= 4'd0;
            out_mps_reg  <= 16'd0;
        end
        else if (fire)
        begin
            cnt_reg      <= cnt_next;
            hlen_reg     <= hlen_next;
            hdr_ok_reg   <= hdr_ok_next;
            cfg_reg      <= cfg_next;
            started_reg  <= started_next;
            stopped_reg  <= stopped_next;
            pos_reg      <= pos_next;
            size_reg     <= size_next;
            type_reg     <= type_next;
            fields_reg   <= fields_next;
            match_reg    <= match_next;
            have_in_reg  <= have_in_next;
            have_out_reg <= have_out_next;
            in_num_reg   <= in_num_next;
            in_mps_reg   <= in_mps_next;
            out_num_reg  <= out_num_next;
            out_mps_reg  <= out_mps_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/msds_out_reg.sv @@
`default_nettype none

module msds_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire msds_pkg::out_item_t res_item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output msds_pkg::out_item_t      result_item
);
    import msds_pkg::*;

    logic      vld_reg;
    out_item_t item_reg;

    assign result_valid = vld_reg;
    assign result_item  = item_reg;

    // Valid flag of the result register; it is only loaded when free or taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            vld_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= res_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/msds_checker.sv @@
`default_nettype none

`include "mass_storage_descriptor_scan_assert.svh"

module msds_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_stall,
    input  wire logic                result_valid,
    input  wire logic                result_stall,
    input  wire msds_pkg::out_item_t result_item
);
    import msds_pkg::*;

    logic rest_zero;

    // Every field beside found is zero.
    assign rest_zero = (result_item.config_value == 8'd0) &&
                       (result_item.in_endpoint == 4'd0) &&
                       (result_item.in_max_packet == 16'd0) &&
                       (result_item.out_endpoint == 4'd0) &&
                       (result_item.out_max_packet == 16'd0);

    // A stalled result stays offered.
    `MSDS_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid)

    // A stalled result keeps its payload.
    `MSDS_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result_item))

    // A result without a match carries zeros in every other field.
    `MSDS_ASSERT_NOW(a_not_found_zero, result_valid && !result_item.found, rest_zero)

    // The byte side is only held back while a result waits at a stalled output.
    `MSDS_ASSERT_NOW(a_stall_cause, byte_stall, result_valid && result_stall)

endmodule

bind mass_storage_descriptor_scan msds_checker u_msds_checker (.*);

`default_nettype wire
